// File: hw/rtl/spfq_pkg.sv
// Shared types and constants for the strict-priority four-queue scheduler.
package spfq_pkg;

  localparam int unsigned NUM_CLASSES = 4;
  localparam int unsigned CLASS_W     = 2;
  localparam int unsigned TID_W       = 8;
  localparam int unsigned TOTAL_W     = 7;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SELECT  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SELECTED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [TID_W-1:0]   thread_id;
    logic [CLASS_W-1:0] priority_class;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [TID_W-1:0]   selected_id;
    logic [CLASS_W-1:0] selected_class;
    logic [TOTAL_W-1:0] total_queued;
  } rsp_t;

endpackage

// File: hw/rtl/strict_priority_four_queue_scheduler.sv
// Each result strobes in the cycle after its request is accepted.
// Throughput: one request per cycle; busy stays low, since the single-port
//   identifier memory sees at most one access per request and read data is ready next cycle.
// Reset: rst_ni clears pointers, counts and the result strobe; the identifier
//   memory is not cleared, as no entry is read before it is written.
// The receiver cannot stall: each result is on rsp_o for the one cycle of valid_o.
module strict_priority_four_queue_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  spfq_pkg::req_t req_i,
  output logic           valid_o,
  output spfq_pkg::rsp_t rsp_o
);

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned ADDR_W = PTR_W + spfq_pkg::CLASS_W;

  logic               accept;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ID_BITS-1:0] mem_wdata;
  logic [ID_BITS-1:0] mem_rdata;

  // Every request needs at most one memory access, so never hold requests off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Pointers, counts and the priority pick; issue at most one memory access per request.
  spfq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .PTR_W       (PTR_W),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_i       (req_i),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .valid_o     (valid_o),
    .rsp_o       (rsp_o)
  );

  // Identifier storage: class selects the region, the queue pointer the slot.
  spfq_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (ID_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// File: hw/rtl/spfq_store.sv
// Synchronous single-port memory holding the thread identifiers of all four queues.
module spfq_store #(
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/spfq_ctrl.sv
// Queue pointers, occupancy counts, priority pick and result formatting.
module spfq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned PTR_W       = $clog2(QUEUE_DEPTH),
  parameter int unsigned ADDR_W      = PTR_W + spfq_pkg::CLASS_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  spfq_pkg::req_t      req_i,
  output logic                mem_we_o,
  output logic                mem_re_o,
  output logic [ADDR_W-1:0]   mem_addr_o,
  output logic [ID_BITS-1:0]  mem_wdata_o,
  input  logic [ID_BITS-1:0]  mem_rdata_i,
  output logic                valid_o,
  output spfq_pkg::rsp_t      rsp_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TOT_W = $clog2(spfq_pkg::NUM_CLASSES * QUEUE_DEPTH + 1);

  logic [PTR_W-1:0] head_q [spfq_pkg::NUM_CLASSES];
  logic [PTR_W-1:0] head_d [spfq_pkg::NUM_CLASSES];
  logic [PTR_W-1:0] tail_q [spfq_pkg::NUM_CLASSES];
  logic [PTR_W-1:0] tail_d [spfq_pkg::NUM_CLASSES];
  logic [CNT_W-1:0] cnt_q  [spfq_pkg::NUM_CLASSES];
  logic [CNT_W-1:0] cnt_d  [spfq_pkg::NUM_CLASSES];
  logic [TOT_W-1:0] tot_q, tot_d;
  logic             valid_q, valid_d;
  spfq_pkg::status_e            status_q, status_d;
  logic [spfq_pkg::CLASS_W-1:0] class_q, class_d;

  logic                         found;
  logic [spfq_pkg::CLASS_W-1:0] pick;
  logic [spfq_pkg::CLASS_W-1:0] cls;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign cls = req_i.priority_class;

  // Highest-priority non-empty class: lowest index wins.
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int c = spfq_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
      if (cnt_q[c] != '0) begin
        found = 1'b1;
        pick  = spfq_pkg::CLASS_W'(c);
      end
    end
  end

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    tot_d       = tot_q;
    valid_d     = accept_i;
    status_d    = status_q;
    class_d     = class_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = {cls, tail_q[cls]};
    mem_wdata_o = ID_BITS'(req_i.thread_id);
    if (accept_i) begin
      class_d = '0;
      if (req_i.op == spfq_pkg::OP_ENQUEUE) begin
        if (cnt_q[cls] == CNT_W'(QUEUE_DEPTH)) begin
          status_d = spfq_pkg::ST_FULL;
        end else begin
          mem_we_o    = 1'b1;
          tail_d[cls] = next_ptr(tail_q[cls]);
          cnt_d[cls]  = cnt_q[cls] + 1'b1;
          tot_d       = tot_q + 1'b1;
          status_d    = spfq_pkg::ST_ENQUEUED;
        end
      end else begin
        if (!found) begin
          status_d = spfq_pkg::ST_EMPTY;
        end else begin
          mem_re_o     = 1'b1;
          mem_addr_o   = {pick, head_q[pick]};
          head_d[pick] = next_ptr(head_q[pick]);
          cnt_d[pick]  = cnt_q[pick] - 1'b1;
          tot_d        = tot_q - 1'b1;
          status_d     = spfq_pkg::ST_SELECTED;
          class_d      = pick;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < spfq_pkg::NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
      tot_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      tot_q   <= tot_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    class_q  <= class_d;
  end

  // Identifier comes straight from the memory read register.
  always_comb begin
    rsp_o.status         = status_q;
    rsp_o.selected_id    = (status_q == spfq_pkg::ST_SELECTED)
                           ? spfq_pkg::TID_W'(mem_rdata_i) : '0;
    rsp_o.selected_class = class_q;
    rsp_o.total_queued   = spfq_pkg::TOTAL_W'(tot_q);
  end

  assign valid_o = valid_q;

  a_total_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tot_q == TOT_W'(cnt_q[0]) + TOT_W'(cnt_q[1]) + TOT_W'(cnt_q[2]) + TOT_W'(cnt_q[3]))
    else $error("running total disagrees with per-class counts");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mem_we_o, mem_re_o}))
    else $error("memory read and write in the same cycle");

  a_result_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(accept_i))
    else $error("result without a request one cycle before");

  a_read_on_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q == spfq_pkg::ST_SELECTED) |-> $past(mem_re_o))
    else $error("selected result without a memory read");

  for (genvar g = 0; g < spfq_pkg::NUM_CLASSES; g++) begin : g_chk
    a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (cnt_q[g] <= CNT_W'(QUEUE_DEPTH)) &&
      ((cnt_q[g] == '0 || cnt_q[g] == CNT_W'(QUEUE_DEPTH)) == (head_q[g] == tail_q[g])))
      else $error("queue count out of step with its pointers");
  end

endmodule
